[src/kpe_pkg.sv]
// Package with the shared constants of the key press event detector.
package kpe_pkg;

   // Number of keys that are watched; higher key bits are ignored.
   localparam int KEY_COUNT = 8;
   localparam int KEY_WIDTH = 8;
   localparam logic [KEY_WIDTH-1:0] KEY_MASK =
      KEY_WIDTH'(((64'd1 << KEY_COUNT) - 64'd1) & 64'hFF);

   localparam int TIME_WIDTH = 32;
   localparam int LIMIT_WIDTH = 16;

   // Phase codes of the press tracker.
   localparam int PHASE_WIDTH = 3;
   localparam logic [PHASE_WIDTH-1:0] PH_IDLE     = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_PRESSING = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_SHORT    = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_LONG     = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_RELPEND  = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_SHORT_MS    = 2'd0;
   localparam logic [1:0] REG_LONG_MS     = 2'd1;
   localparam logic [1:0] REG_REPEAT_MS   = 2'd2;
   localparam logic [1:0] REG_FALLTHROUGH = 2'd3;

   // Reset values of the registers.
   localparam logic [LIMIT_WIDTH-1:0] SHORT_MS_RESET  = 16'd50;
   localparam logic [LIMIT_WIDTH-1:0] LONG_MS_RESET   = 16'd1000;
   localparam logic [LIMIT_WIDTH-1:0] REPEAT_MS_RESET = 16'd250;

   // Bit positions of the event flags in the result tuser.
   localparam int FLAG_SHORT    = 0;
   localparam int FLAG_LONG     = 1;
   localparam int FLAG_REPEAT   = 2;
   localparam int FLAG_RELEASED = 3;

   typedef logic [3:0] flags_type;

endpackage

[src/key_press_event_detector.sv]
// Key press event detector: turns sampled key masks into press events.
//
// Usage: each request transaction carries the sampled key mask and a free
// running millisecond timestamp. For every request exactly one response
// transaction is produced, holding the event key mask in tdata and the
// short, long, repeat and released flags in tuser. A response with all flags
// low is a plain idle report, which echoes the pressed keys when fallthrough
// is enabled and is zero otherwise.
// The response becomes valid in the cycle after its request is accepted.
// Throughput is one transaction per cycle while the receiver does not stall,
// set by the single output register; the whole step is one 32-bit subtract,
// compares and the phase update between the request port and that register.
// When the receiver stalls, the response register holds its transaction and
// a new request is only taken in a cycle where the held one leaves. Reset is
// synchronous and active high; it empties the response register, returns the
// tracker to idle and loads the register defaults (short 50 ms, long 1000 ms,
// repeat 250 ms, fallthrough off). The user must write registers over the
// APB-style port only while no transaction is in flight; not enforced.
module key_press_event_detector
   import kpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] pressed_keys, [39:8] now_ms
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] event_keys
   output logic [3:0]  rsp_tuser,   // [0] is_short, [1] is_long, [2] is_repeat,
                                    // [3] is_released
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers.
   logic [LIMIT_WIDTH-1:0] short_ms_ff, long_ms_ff, repeat_ms_ff;
   logic                   fallthrough_ff;
   logic                   csr_write;
   logic [1:0]             csr_index;

   // Tracker state.
   logic [KEY_WIDTH-1:0]   held_mask_ff, held_mask_in;
   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [TIME_WIDTH-1:0]  start_time_ff, start_time_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KEY_WIDTH-1:0]   rsp_keys_ff, rsp_keys_in;
   flags_type              rsp_flags_ff, rsp_flags_in;

   // Decoded request.
   logic                   req_accept;
   logic [KEY_WIDTH-1:0]   pressed;
   logic [TIME_WIDTH-1:0]  now_ms;
   logic [TIME_WIDTH-1:0]  elapsed;
   logic [KEY_WIDTH-1:0]   idle_keys;
   logic [PHASE_WIDTH-1:0] phase_cur;
   logic [KEY_WIDTH-1:0]   held_cur;

   // ---------------------------------------------------------------------
   // Configuration port. Writes land on the access cycle; reads are direct.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ms_ff    <= SHORT_MS_RESET;
         long_ms_ff     <= LONG_MS_RESET;
         repeat_ms_ff   <= REPEAT_MS_RESET;
         fallthrough_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SHORT_MS:    short_ms_ff    <= csr_pwdata[LIMIT_WIDTH-1:0];
            REG_LONG_MS:     long_ms_ff     <= csr_pwdata[LIMIT_WIDTH-1:0];
            REG_REPEAT_MS:   repeat_ms_ff   <= csr_pwdata[LIMIT_WIDTH-1:0];
            REG_FALLTHROUGH: fallthrough_ff <= csr_pwdata[0];
            default:         fallthrough_ff <= fallthrough_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SHORT_MS:    csr_prdata = {16'd0, short_ms_ff};
         REG_LONG_MS:     csr_prdata = {16'd0, long_ms_ff};
         REG_REPEAT_MS:   csr_prdata = {16'd0, repeat_ms_ff};
         REG_FALLTHROUGH: csr_prdata = {31'd0, fallthrough_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake. A request moves whenever the response register is empty or
   // its transaction leaves in the same cycle.
   // ---------------------------------------------------------------------
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   assign pressed   = req_tdata[KEY_WIDTH-1:0] & KEY_MASK;
   assign now_ms    = req_tdata[KEY_WIDTH +: TIME_WIDTH];
   assign idle_keys = fallthrough_ff ? pressed : '0;
   assign elapsed   = now_ms - start_time_ff;

   // Codes above release pending never occur, but they fall back to idle.
   assign phase_cur = (phase_ff > PH_RELPEND) ? PH_IDLE : phase_ff;
   assign held_cur  = (phase_ff > PH_RELPEND) ? '0 : held_mask_ff;

   // ---------------------------------------------------------------------
   // Event decision. Everything here is one subtract and a few compares.
   // ---------------------------------------------------------------------
   always_comb begin
      held_mask_in  = held_mask_ff;
      phase_in      = phase_ff;
      start_time_in = start_time_ff;
      rsp_keys_in   = rsp_keys_ff;
      rsp_flags_in  = rsp_flags_ff;

      if (req_accept) begin
         held_mask_in = held_cur;
         phase_in     = phase_cur;
         rsp_keys_in  = idle_keys;
         rsp_flags_in = '0;

         priority if (phase_cur == PH_RELPEND) begin
            // The transaction after a release report is always a bare release.
            phase_in                    = PH_IDLE;
            held_mask_in                = '0;
            rsp_keys_in                 = '0;
            rsp_flags_in[FLAG_RELEASED] = 1'b1;
         end else if (pressed == '0) begin
            phase_in     = PH_IDLE;
            held_mask_in = '0;
            rsp_keys_in  = '0;
            if (phase_cur == PH_LONG) begin
               phase_in                    = PH_RELPEND;
               rsp_keys_in                 = held_cur;
               rsp_flags_in[FLAG_LONG]     = 1'b1;
               rsp_flags_in[FLAG_RELEASED] = 1'b1;
            end else if (phase_cur == PH_SHORT) begin
               phase_in                    = PH_RELPEND;
               rsp_keys_in                 = held_cur;
               rsp_flags_in[FLAG_SHORT]    = 1'b1;
               rsp_flags_in[FLAG_RELEASED] = 1'b1;
            end
         end else if ((pressed & ~held_cur) != '0) begin
            // A newly pressed key restarts timing.
            held_mask_in  = (held_cur | pressed) & KEY_MASK;
            phase_in      = PH_PRESSING;
            start_time_in = now_ms;
         end else if ((phase_cur == PH_PRESSING) &&
                      (elapsed > {16'd0, short_ms_ff})) begin
            held_mask_in             = pressed;
            phase_in                 = PH_SHORT;
            rsp_keys_in              = pressed;
            rsp_flags_in[FLAG_SHORT] = 1'b1;
         end else if (phase_cur == PH_LONG) begin
            if (elapsed > {16'd0, repeat_ms_ff}) begin
               start_time_in             = now_ms;
               rsp_keys_in               = held_cur;
               rsp_flags_in[FLAG_REPEAT] = 1'b1;
            end
         end else begin
            // Long may also fire straight from pressing when long_ms is small.
            if (elapsed > {16'd0, long_ms_ff}) begin
               phase_in                = PH_LONG;
               start_time_in           = now_ms;
               rsp_keys_in             = held_cur;
               rsp_flags_in[FLAG_LONG] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_mask_ff  <= '0;
         phase_ff      <= PH_IDLE;
         start_time_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_mask_ff  <= held_mask_in;
         phase_ff      <= phase_in;
         start_time_ff <= start_time_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // The response payload needs no reset; it only counts while valid.
   always_ff @(posedge clock) begin
      rsp_keys_ff  <= rsp_keys_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_keys_ff;
   assign rsp_tuser  = rsp_flags_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // Idle and release pending both keep an empty held mask.
   a_held_clear : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE || phase_ff == PH_RELPEND) |-> (held_mask_ff == '0))
      else $error("held mask not clear in idle or release pending");

   // A transaction taken in release pending yields a bare release.
   a_bare_release : assert property (@(posedge clock) disable iff (reset)
      (req_accept && phase_ff == PH_RELPEND) |=>
         (rsp_tvalid && rsp_tdata == '0 && rsp_tuser == (4'd1 << FLAG_RELEASED)))
      else $error("release pending did not produce a bare release");

   // Short and long never appear together, nor repeat with release.
   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!(rsp_tuser[FLAG_SHORT] && rsp_tuser[FLAG_LONG]) &&
                      !(rsp_tuser[FLAG_REPEAT] && rsp_tuser[FLAG_RELEASED])))
      else $error("conflicting event flags");

   // A release report always moves the tracker to release pending.
   a_release_phase : assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_flags_in[FLAG_RELEASED] &&
       (rsp_flags_in[FLAG_SHORT] || rsp_flags_in[FLAG_LONG])) |=>
         (phase_ff == PH_RELPEND))
      else $error("release report without release pending");

endmodule

[verif/tb_key_press_event_detector.sv]
// Self-checking testbench of the key press event detector: stream and register checks.
`timescale 1ns / 100ps

module tb_key_press_event_detector
   import kpe_pkg::*;
();

   // This bound only catches a hung block.
   localparam int CYCLE_LIMIT  = 200000;
   // Chance in percent that either side idles in a given cycle.
   localparam int IDLE_PERCENT = 6;

   // One response transaction: the event key mask and the four event flags.
   typedef struct packed {
      logic [KEY_WIDTH-1:0] keys;
      flags_type            flags;
   } key_event_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;  // [7:0] pressed_keys, [39:8] now_ms
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] event_keys
   logic [3:0]  rsp_tuser;         // [0] is_short, [1] is_long, [2] is_repeat,
                                   // [3] is_released
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Mirror of the tracker state and of the registers, kept by the predictor.
   logic [KEY_WIDTH-1:0]   held_keys;
   logic [PHASE_WIDTH-1:0] press_phase;
   logic [TIME_WIDTH-1:0]  hold_start;
   logic [LIMIT_WIDTH-1:0] short_lim;
   logic [LIMIT_WIDTH-1:0] long_lim;
   logic [LIMIT_WIDTH-1:0] repeat_lim;
   logic                   echo_on;

   // Events predicted for accepted requests, oldest first.
   key_event_type pending_events[$];

   int error_count    = 0;
   int sent_count     = 0;
   int checked_count  = 0;
   int settings_count = 1;
   int short_seen     = 0;
   int long_seen      = 0;
   int repeat_seen    = 0;
   int release_seen   = 0;
   int cycle_count    = 0;
   int hold_left      = 0;
   bit steady         = 1'b0;

   string flag_name[4] = '{"is_short", "is_long", "is_repeat", "is_released"};

   key_press_event_detector u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Watchdog: a block that stops answering ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("[key_press_event_detector] ERROR");
         $finish;
      end
   end

   // Works out the event for one key sample and advances the mirrored tracker.
   // Timing restarts whenever a key shows up that is not yet held; every
   // threshold compare is strictly greater-than on a wrapping 32-bit difference.
   function automatic key_event_type next_key_event(input logic [KEY_WIDTH-1:0] keys_in,
                                                    input logic [TIME_WIDTH-1:0] stamp);
      logic [KEY_WIDTH-1:0]  pressed;
      logic [TIME_WIDTH-1:0] elapsed;
      key_event_type         ev;
      pressed  = keys_in & KEY_MASK;
      ev.keys  = echo_on ? pressed : '0;
      ev.flags = '0;
      if (press_phase > PH_RELPEND) begin
         press_phase = PH_IDLE;
         held_keys   = '0;
      end
      if (press_phase == PH_RELPEND) begin
         // The sample after a reported release only closes the gesture.
         press_phase               = PH_IDLE;
         held_keys                 = '0;
         ev.keys                   = '0;
         ev.flags[FLAG_RELEASED]   = 1'b1;
      end else if (pressed == '0) begin
         ev.keys = '0;
         if (press_phase == PH_LONG) begin
            ev.keys                 = held_keys;
            ev.flags[FLAG_LONG]     = 1'b1;
            ev.flags[FLAG_RELEASED] = 1'b1;
            press_phase             = PH_RELPEND;
         end else if (press_phase == PH_SHORT) begin
            ev.keys                 = held_keys;
            ev.flags[FLAG_SHORT]    = 1'b1;
            ev.flags[FLAG_RELEASED] = 1'b1;
            press_phase             = PH_RELPEND;
         end else begin
            // Let go before short was reached: nothing to report.
            press_phase = PH_IDLE;
         end
         held_keys = '0;
      end else if ((pressed & ~held_keys) != '0) begin
         held_keys   = (held_keys | pressed) & KEY_MASK;
         press_phase = PH_PRESSING;
         hold_start  = stamp;
      end else begin
         elapsed = stamp - hold_start;
         if (press_phase == PH_PRESSING && elapsed > TIME_WIDTH'(short_lim)) begin
            // Short narrows the held mask to what is pressed now.
            held_keys            = pressed;
            press_phase          = PH_SHORT;
            ev.keys              = pressed;
            ev.flags[FLAG_SHORT] = 1'b1;
         end else if (press_phase == PH_LONG) begin
            if (elapsed > TIME_WIDTH'(repeat_lim)) begin
               hold_start            = stamp;
               ev.keys               = held_keys;
               ev.flags[FLAG_REPEAT] = 1'b1;
            end
         end else if (elapsed > TIME_WIDTH'(long_lim)) begin
            // Long may come straight from pressing when it is below short.
            press_phase         = PH_LONG;
            hold_start          = stamp;
            ev.keys             = held_keys;
            ev.flags[FLAG_LONG] = 1'b1;
         end
      end
      return ev;
   endfunction

   // Receiver: stalls at random, not at all during the steady stretch, and for
   // a whole counted stretch when a hold-off has been requested.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Every accepted response is compared, field by field, with the oldest
   // predicted event.
   always @(posedge clock) begin : rsp_check
      key_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual keys %h flags %b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_tdata !== want.keys) begin
               $display("%0t: event_keys expected %h actual %h", $time, want.keys, rsp_tdata);
               error_count++;
            end
            for (int b = 0; b < 4; b++) begin
               if (rsp_tuser[b] !== want.flags[b]) begin
                  $display("%0t: %s expected %b actual %b",
                           $time, flag_name[b], want.flags[b], rsp_tuser[b]);
                  error_count++;
               end
            end
            checked_count++;
         end
         short_seen   += rsp_tuser[FLAG_SHORT];
         long_seen    += rsp_tuser[FLAG_LONG];
         repeat_seen  += rsp_tuser[FLAG_REPEAT];
         release_seen += rsp_tuser[FLAG_RELEASED];
      end
   end

   // Offers one key sample, with random idle cycles in front of it, and records
   // its predicted event once the transaction is accepted. Valid stays high
   // afterward so that samples can follow back to back.
   task automatic offer_sample(input logic [KEY_WIDTH-1:0] keys,
                               input logic [TIME_WIDTH-1:0] stamp);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stamp, keys};
      do @(posedge clock); while (!req_tready);
      pending_events.push_back(next_key_event(keys, stamp));
      sent_count++;
   endtask

   // Stops offering and waits until every predicted event has been seen.
   task automatic wait_all_done();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Reads one register and compares it with the mirrored value.
   task automatic read_reg_check(input logic [1:0] idx);
      logic [31:0] want;
      case (idx)
         REG_SHORT_MS:  want = 32'(short_lim);
         REG_LONG_MS:   want = 32'(long_lim);
         REG_REPEAT_MS: want = 32'(repeat_lim);
         default:       want = 32'(echo_on);
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $display("%0t: register %0d read expected %h actual %h", $time, idx, want, csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Writes one register, with random bits above the field, then reads it back.
   task automatic write_reg(input logic [1:0] idx, input logic [LIMIT_WIDTH-1:0] value);
      logic [31:0] junk;
      junk = $urandom;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= (idx == REG_FALLTHROUGH) ? {junk[31:1], value[0]} : {junk[31:16], value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_SHORT_MS:  short_lim  = value;
         REG_LONG_MS:   long_lim   = value;
         REG_REPEAT_MS: repeat_lim = value;
         default:       echo_on    = value[0];
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      read_reg_check(idx);
   endtask

   // Loads a full register setting once the block has gone idle.
   task automatic apply_settings(input logic [LIMIT_WIDTH-1:0] s, input logic [LIMIT_WIDTH-1:0] l,
                                 input logic [LIMIT_WIDTH-1:0] r, input logic e);
      wait_all_done();
      write_reg(REG_SHORT_MS, s);
      write_reg(REG_LONG_MS, l);
      write_reg(REG_REPEAT_MS, r);
      write_reg(REG_FALLTHROUGH, LIMIT_WIDTH'(e));
      settings_count++;
   endtask

   // Random gestures: press a key set, hold it with time stamps aimed at the
   // short, long and repeat boundaries of the current setting, sometimes drop
   // or add keys, then release and send one more sample for the bare release.
   // About one gesture in ten is replaced by an arbitrary sample.
   task automatic run_gestures(input int count);
      int                    stop_at;
      int                    length;
      logic [KEY_WIDTH-1:0]  keys;
      logic [KEY_WIDTH-1:0]  tail_keys;
      logic [TIME_WIDTH-1:0] stamp;
      stop_at = sent_count + count;
      stamp   = $urandom;
      while (sent_count < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            offer_sample(KEY_WIDTH'($urandom), $urandom);
         end else begin
            keys  = KEY_WIDTH'($urandom_range(1, 255));
            stamp = stamp + $urandom_range(0, 5000);
            offer_sample(keys, stamp);
            length = $urandom_range(1, 10);
            repeat (length) begin
               // Boundary targets are taken from the last restart of timing,
               // one below, at, and just above each limit.
               case ($urandom_range(0, 4))
                  0:       stamp = hold_start + short_lim + $urandom_range(0, 3) - 1;
                  1:       stamp = hold_start + long_lim + $urandom_range(0, 3) - 1;
                  2:       stamp = hold_start + repeat_lim + $urandom_range(0, 3) - 1;
                  3:       stamp = stamp + $urandom_range(0, 400);
                  default: stamp = stamp + $urandom_range(0, 3);
               endcase
               if ($urandom_range(0, 9) == 0) begin
                  keys = keys & KEY_WIDTH'($urandom);
               end else if ($urandom_range(0, 11) == 0) begin
                  keys = keys | KEY_WIDTH'(1 << $urandom_range(0, KEY_COUNT - 1));
               end
               offer_sample(keys, stamp);
            end
            stamp = stamp + $urandom_range(0, 100);
            offer_sample('0, stamp);
            tail_keys = ($urandom_range(0, 3) == 0) ? KEY_WIDTH'($urandom) : '0;
            stamp     = stamp + $urandom_range(0, 100);
            offer_sample(tail_keys, stamp);
         end
      end
   endtask

   // The registers come out of reset with their documented defaults.
   task automatic test_register_defaults();
      read_reg_check(REG_SHORT_MS);
      read_reg_check(REG_LONG_MS);
      read_reg_check(REG_REPEAT_MS);
      read_reg_check(REG_FALLTHROUGH);
   endtask

   // Hand-picked gestures under the default setting: the exact threshold
   // edges, both kinds of release, a release too early to report, a restart
   // by a new key, dropped keys while held, and time stamps wrapping past zero.
   task automatic test_directed_timing();
      logic [TIME_WIDTH-1:0] t0;
      t0 = 32'h1000_0000;
      offer_sample(8'h01, t0);
      offer_sample(8'h01, t0 + 50);
      offer_sample(8'h01, t0 + 51);
      offer_sample(8'h01, t0 + 1001);
      offer_sample(8'h01, t0 + 1251);
      offer_sample(8'h01, t0 + 1252);
      offer_sample(8'h00, t0 + 1300);
      offer_sample(8'hFF, t0 + 1301);
      offer_sample(8'h80, t0 + 2000);
      offer_sample(8'h00, t0 + 2010);
      offer_sample(8'h03, t0 + 3000);
      offer_sample(8'h03, t0 + 3051);
      offer_sample(8'h07, t0 + 3052);
      offer_sample(8'h07, t0 + 3103);
      offer_sample(8'h00, t0 + 3104);
      offer_sample(8'h00, t0 + 3105);
      offer_sample(8'hFF, t0 + 4000);
      offer_sample(8'hFF, t0 + 4051);
      offer_sample(8'h0F, t0 + 5001);
      offer_sample(8'h00, t0 + 5002);
      offer_sample(8'h00, t0 + 5003);
      offer_sample(8'h5A, 32'hFFFF_FFF0);
      offer_sample(8'h5A, 32'h0000_0022);
      offer_sample(8'h5A, 32'h0000_0023);
   endtask

   // Zero limits with the raw keys echoed, then a long limit below the short
   // one, so that long fires straight from pressing.
   task automatic test_fallthrough_zero_limits();
      logic [TIME_WIDTH-1:0] t0;
      t0 = 32'h8000_0000;
      apply_settings(16'd0, 16'd0, 16'd0, 1'b1);
      offer_sample(8'h01, t0);
      offer_sample(8'h01, t0);
      offer_sample(8'h01, t0 + 1);
      offer_sample(8'h01, t0 + 1);
      offer_sample(8'h01, t0 + 1);
      offer_sample(8'h01, t0 + 2);
      offer_sample(8'h00, t0 + 2);
      offer_sample(8'h00, t0 + 2);
      apply_settings(16'd100, 16'd20, 16'd5, 1'b0);
      offer_sample(8'hC3, t0);
      offer_sample(8'hC3, t0 + 21);
      offer_sample(8'h00, t0 + 22);
      offer_sample(8'h00, t0 + 23);
   endtask

   // Random gestures under a series of settings, the extremes among them.
   // The default setting runs as a stretch without any idle cycles.
   task automatic test_random_settings();
      apply_settings(SHORT_MS_RESET, LONG_MS_RESET, REPEAT_MS_RESET, 1'b0);
      steady = 1'b1;
      run_gestures(95);
      wait_all_done();
      steady = 1'b0;
      apply_settings(16'd0, 16'd0, 16'd0, 1'b1);
      run_gestures(95);
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      run_gestures(95);
      apply_settings(LIMIT_WIDTH'($urandom), LIMIT_WIDTH'($urandom), LIMIT_WIDTH'($urandom),
                     1'($urandom));
      run_gestures(95);
      apply_settings(LIMIT_WIDTH'($urandom_range(1, 20)), LIMIT_WIDTH'($urandom_range(0, 60)),
                     LIMIT_WIDTH'($urandom_range(0, 20)), 1'b1);
      run_gestures(95);
      apply_settings(LIMIT_WIDTH'($urandom_range(200, 400)), LIMIT_WIDTH'($urandom_range(0, 150)),
                     LIMIT_WIDTH'($urandom_range(0, 30)), 1'($urandom));
      run_gestures(95);
   endtask

   // The receiver holds off for a long counted stretch while samples keep
   // coming, so the response register fills and the request side stalls.
   // Then the sender pauses until everything has drained and resumes.
   task automatic test_backpressure();
      apply_settings(16'd10, 16'd40, 16'd5, 1'b1);
      @(posedge clock);
      hold_left = 80;
      run_gestures(30);
      wait_all_done();
      run_gestures(20);
   endtask

   initial begin
      short_lim   = SHORT_MS_RESET;
      long_lim    = LONG_MS_RESET;
      repeat_lim  = REPEAT_MS_RESET;
      echo_on     = 1'b0;
      held_keys   = '0;
      press_phase = PH_IDLE;
      hold_start  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_defaults();
      test_directed_timing();
      test_fallthrough_zero_limits();
      test_random_settings();
      test_backpressure();

      wait_all_done();
      repeat (10) @(posedge clock);
      $display("Checked %0d of %0d key sample transactions under %0d register settings.",
               checked_count, sent_count, settings_count);
      $display("Events seen: %0d short, %0d long, %0d repeat, %0d with release.",
               short_seen, long_seen, repeat_seen, release_seen);
      if (error_count == 0) begin
         $display("[key_press_event_detector] OK");
      end else begin
         $display("[key_press_event_detector] ERROR");
      end
      $finish;
   end

endmodule
